// ===== sv/assert_macros.svh =====
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/iff_pkg.sv =====
// Types and constants of the integer field formatter.
package iff_pkg;
    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_OCT  = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;
    localparam logic [1:0] LEN_SHORT = 2'd1;
    localparam logic [1:0] LEN_LONG  = 2'd2;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [1:0] radix;  // 0 decimal, 1 octal, 2 hex
        logic [64:0] mag;
    } t_div_req;

    typedef struct packed {
        logic       busy;
        logic       done;
    } t_div_stat;
endpackage

// ===== sv/iff_if.sv =====
// Valid/ready channel interfaces for requests and characters.
interface iff_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] value;
    logic [1:0]  length_mod;
    logic [4:0]  flag_bits;
    logic [6:0]  field_width;
    logic [5:0]  min_digits;
    logic        precision_given;
    modport source (output valid, cmd, value, length_mod, flag_bits, field_width,
                    min_digits, precision_given, input ready);
    modport sink (input valid, cmd, value, length_mod, flag_bits, field_width,
                  min_digits, precision_given, output ready);
endinterface

interface iff_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;
    modport source (output valid, out_char, is_last, input ready);
    modport sink (input valid, out_char, is_last, output ready);
endinterface

// ===== sv/iff_digit_unit.sv =====
// Shared digit extractor: decimal digits by a byte-wide divide-by-ten step,
// octal and hex digits by shifting. Digits are stored least significant first.
module iff_digit_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  iff_pkg::t_div_req     i_req,
    input  logic [4:0]            i_rd_idx,
    output logic [3:0]            o_rd_digit,
    output logic [4:0]            o_count,
    output iff_pkg::t_div_stat    o_stat
);
    logic [64:0] r_val;
    logic [63:0] r_quot;
    logic [1:0]  r_radix;
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [2:0]  r_bsel;
    logic [3:0]  r_rem;
    logic [3:0]  r_dig [32];

    logic [64:0] n_shift;
    logic [3:0]  n_srem;
    logic [11:0] n_part;
    logic [23:0] n_prod;
    logic [7:0]  n_qbyte;
    logic [3:0]  n_brem;
    logic [63:0] n_quot;

    // Octal and hex digits come straight from the low bits.
    always_comb begin
        if (r_radix == 2'd1) begin
            n_shift = r_val >> 3;
            n_srem  = {1'b0, r_val[2:0]};
        end else begin
            n_shift = r_val >> 4;
            n_srem  = r_val[3:0];
        end
    end

    // One byte of the decimal long division per cycle. The running remainder
    // and the next byte form a value below 2560, which is divided by ten by
    // multiplying with 3277 / 32768; that is exact over the whole range.
    always_comb begin
        n_part  = {r_rem, r_val[{r_bsel, 3'b000} +: 8]};
        n_prod  = n_part * 12'd3277;
        n_qbyte = n_prod[22:15];
        n_brem  = 4'(n_part - 12'(n_qbyte) * 12'd10);
        n_quot  = r_quot;
        n_quot[{r_bsel, 3'b000} +: 8] = n_qbyte;
    end

    // Sequencing of the extraction: a decimal digit takes a long division over all eight
    // bytes of the value, an octal or hex digit a single shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_val   <= i_req.mag;
            r_radix <= i_req.radix;
            r_bsel  <= 3'd7;
            r_rem   <= {3'b000, i_req.mag[64]};
        end else if (r_busy && r_radix != 2'd0) begin
            r_dig[r_cnt] <= n_srem;
            r_val        <= n_shift;
            r_cnt        <= r_cnt + 5'd1;
            if (n_shift == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_busy) begin
            r_quot <= n_quot;
            if (r_bsel != 3'd0) begin
                r_bsel <= r_bsel - 3'd1;
                r_rem  <= n_brem;
            end else begin
                r_dig[r_cnt] <= n_brem;
                r_val        <= {1'b0, n_quot};
                r_cnt        <= r_cnt + 5'd1;
                r_bsel       <= 3'd7;
                r_rem        <= 4'd0;
                if (n_quot == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rd_digit  = r_dig[i_rd_idx];
    assign o_count     = r_cnt;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

// ===== sv/integer_field_formatter_core.sv =====
// Top level of the integer field formatter.
// Usage: one conversion request is taken on the request channel (i_req) when
// valid and ready are high; the formatted field then leaves on the character
// channel (o_chr), one character per transfer, the last one marked is_last.
// The request is registered, then the shared digit unit extracts the digits: decimal
// ones by long division (up to 20 digits), octal or hex ones by shifting (up to 22
// or 16). The field then leaves character by character through the output register.
// Ready is low from acceptance until the last character has been taken.
// Unknown conversion codes are accepted and give no characters.
// Reset clears the sequencer and the output valid; no characters survive it.
// When the receiver stalls, the current character is held in the output
// register and the sequencer waits; nothing is lost or repeated.
// MAX_CHARS bounds width and precision and truncates overlong fields.
module integer_field_formatter_core #(
    parameter int MAX_CHARS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    iff_req_if.sink   i_req,
    iff_chr_if.source o_chr
);
`include "assert_macros.svh"

    iff_pkg::t_state r_state, n_state;
    logic [2:0] r_cmd;
    logic       r_left, r_zero, r_nz;
    logic [7:0] r_sign;
    logic [1:0] r_pre;
    logic [6:0] r_width;
    logic [5:0] r_prec;
    logic [6:0] r_pos;      // position within the whole field
    logic [6:0] r_total;
    logic [7:0] r_pad;
    logic [6:0] r_zeros;
    logic [4:0] r_nd;
    logic       r_ov;
    logic [7:0] r_char;
    logic       r_last;

    iff_pkg::t_div_req  div_req;
    iff_pkg::t_div_stat div_stat;
    logic [4:0] rd_idx, dcount;
    logic [3:0] rd_digit;

    // Flag cancellation and operand selection on the request.
    logic       c_left, c_plus, c_space, c_alt, c_zero, c_neg;
    logic [5:0] c_prec;
    logic [6:0] c_width;
    logic [64:0] c_mag;
    logic [7:0] c_sign;
    always_comb begin
        logic [2:0] cm;
        cm      = i_req.cmd;
        c_left  = i_req.flag_bits[0];
        c_plus  = i_req.flag_bits[1];
        c_space = i_req.flag_bits[2];
        c_alt   = i_req.flag_bits[3];
        c_zero  = i_req.flag_bits[4];
        c_prec  = i_req.precision_given ? i_req.min_digits : 6'd0;
        if (32'(c_prec) > MAX_CHARS - 2) c_prec = 6'(MAX_CHARS - 2);
        c_width = (32'(i_req.field_width) > MAX_CHARS) ? 7'(MAX_CHARS) : i_req.field_width;
        if (c_prec != 6'd0) c_zero = 1'b0;
        if (cm <= iff_pkg::CMD_UDEC) c_alt = 1'b0;
        if (cm != iff_pkg::CMD_SDEC) begin
            c_plus  = 1'b0;
            c_space = 1'b0;
        end
        if (cm >= iff_pkg::CMD_HEXL && c_alt) c_zero = 1'b0;
        if (c_left) c_zero = 1'b0;
        if (c_plus) c_space = 1'b0;
        c_neg = 1'b0;
        case (i_req.length_mod)
            iff_pkg::LEN_SHORT: begin
                c_mag = {49'd0, i_req.value[15:0]};
                if (cm == iff_pkg::CMD_SDEC && i_req.value[15]) begin
                    c_neg = 1'b1;
                    c_mag = 65'h10000 - c_mag;
                end
            end
            iff_pkg::LEN_LONG: begin
                c_mag = {1'b0, i_req.value};
                if (cm == iff_pkg::CMD_SDEC && i_req.value[63]) begin
                    c_neg = 1'b1;
                    c_mag = {1'b0, 64'd0 - i_req.value};
                end
            end
            default: begin
                c_mag = {33'd0, i_req.value[31:0]};
                if (cm == iff_pkg::CMD_SDEC && i_req.value[31]) begin
                    c_neg = 1'b1;
                    c_mag = 65'h100000000 - c_mag;
                end
            end
        endcase
        if (c_neg) c_sign = iff_pkg::CH_MINUS;
        else if (c_plus) c_sign = iff_pkg::CH_PLUS;
        else if (c_space) c_sign = iff_pkg::CH_SPACE;
        else c_sign = 8'd0;
    end

    assign div_req.start = (r_state == iff_pkg::ST_IDLE) && i_req.valid &&
                           (i_req.cmd <= iff_pkg::CMD_HEXU);
    assign div_req.radix = (i_req.cmd <= iff_pkg::CMD_UDEC) ? 2'd0 :
                           (i_req.cmd == iff_pkg::CMD_OCT) ? 2'd1 : 2'd2;
    assign div_req.mag   = c_mag;

    iff_digit_unit u_digits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_rd_idx   (rd_idx),
        .o_rd_digit (rd_digit),
        .o_count    (dcount),
        .o_stat     (div_stat)
    );

    // Field layout once the digit count is known.
    logic [1:0] l_pre;
    logic [6:0] l_zeros, l_len;
    logic [7:0] l_pad, l_total;
    always_comb begin
        l_pre = 2'd0;
        if (r_nz && r_pre != 2'd0) begin
            if (r_cmd == iff_pkg::CMD_OCT) l_pre = (7'(r_prec) < 7'(dcount)) ? 2'd1 : 2'd0;
            else l_pre = 2'd2;
        end
        l_zeros = (7'(r_prec) > 7'(dcount)) ? 7'(r_prec) - 7'(dcount) : 7'd0;
        l_len   = 7'(r_sign != 8'd0) + 7'(l_pre) + l_zeros + 7'(dcount);
        l_pad   = (r_width > l_len) ? 8'(r_width - l_len) : 8'd0;
        l_total = 8'(l_len) + l_pad;
    end

    // Character at the current position.
    logic [7:0] e_char;
    logic [7:0] e_p;
    always_comb begin
        logic [7:0] sgn, lead, pz, dg;
        e_p  = {1'b0, r_pos};
        sgn  = 8'(r_sign != 8'd0);
        lead = (!r_left && !r_zero) ? r_pad : 8'd0;
        pz   = r_zero ? r_pad : 8'd0;
        dg   = 8'd0;
        rd_idx = '0;
        e_char = iff_pkg::CH_SPACE;
        if (e_p < lead) e_char = iff_pkg::CH_SPACE;
        else if (e_p < lead + sgn) e_char = r_sign;
        else if (e_p < lead + sgn + pz) e_char = iff_pkg::CH_ZERO;
        else if (e_p < lead + sgn + pz + 8'(r_pre)) begin
            if (e_p == lead + sgn + pz) e_char = iff_pkg::CH_ZERO;
            else e_char = (r_cmd == iff_pkg::CMD_HEXU) ? iff_pkg::CH_UX : iff_pkg::CH_LX;
        end else if (e_p < lead + sgn + pz + 8'(r_pre) + 8'(r_zeros))
            e_char = iff_pkg::CH_ZERO;
        else if (e_p < lead + sgn + pz + 8'(r_pre) + 8'(r_zeros) + 8'(r_nd)) begin
            dg     = e_p - (lead + sgn + pz + 8'(r_pre) + 8'(r_zeros));
            rd_idx = 5'(8'(r_nd) - 8'd1 - dg);
            if (rd_digit < 4'd10) e_char = iff_pkg::CH_ZERO + 8'(rd_digit);
            else e_char = ((r_cmd == iff_pkg::CMD_HEXU) ? iff_pkg::CH_UA : iff_pkg::CH_LA)
                          + 8'(rd_digit) - 8'd10;
        end
    end

    logic out_free;
    assign out_free = !o_chr.valid || o_chr.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            iff_pkg::ST_IDLE:
                if (div_req.start) n_state = iff_pkg::ST_DIGIT;
            iff_pkg::ST_DIGIT:
                if (div_stat.done) n_state = iff_pkg::ST_EMIT;
            iff_pkg::ST_EMIT:
                if (out_free && r_pos == r_total) n_state = iff_pkg::ST_IDLE;
            default: n_state = iff_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_req.ready = (r_state == iff_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iff_pkg::ST_IDLE;
            r_char  <= '0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == iff_pkg::ST_IDLE && i_req.valid) begin
                r_cmd   <= i_req.cmd;
                r_left  <= c_left;
                r_zero  <= c_zero;
                r_sign  <= c_sign;
                r_pre   <= c_alt ? 2'd1 : 2'd0;
                r_nz    <= (c_mag != '0);
                r_prec  <= c_prec;
                r_width <= c_width;
            end
            if (r_state == iff_pkg::ST_DIGIT && div_stat.done) begin
                r_pre   <= l_pre;
                r_zeros <= l_zeros;
                r_nd    <= dcount;
                r_pad   <= l_pad;
                r_total <= (l_total > 8'(MAX_CHARS)) ? 7'(MAX_CHARS) : 7'(l_total);
                r_pos   <= 7'd0;
            end
            // Load the next character, or drop valid once the held one is taken.
            if (r_state == iff_pkg::ST_EMIT && out_free && r_pos != r_total) begin
                r_char <= e_char;
                r_last <= (r_pos + 7'd1 == r_total);
                r_ov   <= 1'b1;
                r_pos  <= r_pos + 7'd1;
            end else if (o_chr.valid && o_chr.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_chr.valid    = r_ov;
    assign o_chr.out_char = r_char;
    assign o_chr.is_last  = r_last;

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n,
        r_state != iff_pkg::ST_IDLE, !i_req.ready, "ready while busy")
    `ASSERT_IMPL(a_out_only_emit, i_clk, i_rst_n,
        o_chr.valid && o_chr.ready && o_chr.is_last, r_state == iff_pkg::ST_EMIT,
        "last character outside emission")
    `ASSERT_NEXT(a_digits_done, i_clk, i_rst_n,
        r_state == iff_pkg::ST_DIGIT && div_stat.done, r_state == iff_pkg::ST_EMIT,
        "emission did not start")
endmodule
